[rtl/core/csa_pkg.sv]
// Shared constants, codes and types of the contiguous segment allocator.
// No dependencies; every other file imports this package.
`default_nettype none

package csa_pkg;

   localparam int MAX_SEGMENTS = 32;
   localparam int ADDR_BITS    = 20;
   localparam int OWNER_BITS   = 16;
   localparam int IDX_BITS     = $clog2(MAX_SEGMENTS);
   localparam int CNT_BITS     = $clog2(MAX_SEGMENTS + 1);
   localparam int LEN_BITS     = 21;
   localparam int CMD_BITS     = 2;
   localparam int POLICY_BITS  = 2;
   localparam int STATUS_BITS  = 3;
   localparam int RCNT_BITS    = 6;

   localparam logic [LEN_BITS-1:0] MEM_LIMIT = LEN_BITS'(1) << ADDR_BITS;

   localparam logic [CMD_BITS-1:0] CMD_REQUEST = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_RELEASE = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_COMPACT = 2'd2;

   localparam logic [POLICY_BITS-1:0] POL_BEST  = 2'd1;
   localparam logic [POLICY_BITS-1:0] POL_WORST = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_NOFIT     = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_NOOWNER   = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_NOCOMPACT = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd4;

   typedef struct packed {
      logic [OWNER_BITS-1:0] owner;
      logic [ADDR_BITS-1:0]  start;
      logic [LEN_BITS-1:0]   len;
   } seg_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_INIT,
      OP_LOAD,
      OP_SCAN,
      OP_TAKE,
      OP_SHIFT_INIT,
      OP_SHIFT,
      OP_SPLIT_LO,
      OP_SPLIT_HI,
      OP_REL,
      OP_FLUSH,
      OP_SUM,
      OP_REWIND,
      OP_PACK,
      OP_LIFT_INIT,
      OP_LIFT,
      OP_HOLE,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic [STATUS_BITS-1:0] status;
   } ctl_type;

   typedef struct packed {
      logic [CMD_BITS-1:0] cmd;
      logic                owner_zero;
      logic                size_zero;
      logic                count_le1;
      logic                scan_last;
      logic                found;
      logic                exact;
      logic                full;
      logic                shift_done;
      logic                n_zero;
      logic                free_zero;
      logic                lift_done;
      logic                rsp_free;
   } sts_type;

endpackage

`default_nettype wire

[rtl/core/csa_if.sv]
// Valid/ready channel interfaces: request, response and register write.
// Depends on csa_pkg for field widths.
`default_nettype none

interface csa_req_if
   import csa_pkg::*;
   ;
   logic                   valid;
   logic                   ready;
   logic [CMD_BITS-1:0]    cmd;
   logic [OWNER_BITS-1:0]  owner_id;
   logic [LEN_BITS-1:0]    request_size;
   logic [POLICY_BITS-1:0] fit_policy;
   modport source (output valid, cmd, owner_id, request_size, fit_policy, input ready);
   modport sink (input valid, cmd, owner_id, request_size, fit_policy, output ready);
endinterface

interface csa_rsp_if
   import csa_pkg::*;
   ;
   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [ADDR_BITS-1:0]   start_address;
   logic [RCNT_BITS-1:0]   released_count;
   modport source (output valid, status, start_address, released_count, input ready);
   modport sink (input valid, status, start_address, released_count, output ready);
endinterface

interface csa_csr_if
   import csa_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [LEN_BITS-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

[rtl/core/csa_dpath.sv]
// Datapath: segment table, scan indices, accumulators and response register.
// Depends on csa_pkg; driven by csa_ctrl through ctl_type commands.
`default_nettype none

module csa_dpath
   import csa_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ctl_type                ctl,
   output sts_type                     sts,
   input  wire logic [CMD_BITS-1:0]    req_cmd,
   input  wire logic [OWNER_BITS-1:0]  req_owner_id,
   input  wire logic [LEN_BITS-1:0]    req_request_size,
   input  wire logic [POLICY_BITS-1:0] req_fit_policy,
   input  wire logic [LEN_BITS-1:0]    csr_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [STATUS_BITS-1:0]      rsp_status,
   output logic [ADDR_BITS-1:0]        rsp_start_address,
   output logic [RCNT_BITS-1:0]        rsp_released_count
);

   seg_type                table_ff [MAX_SEGMENTS];
   logic [CNT_BITS-1:0]    count_ff;
   logic [CNT_BITS-1:0]    i_ff;
   logic [CNT_BITS-1:0]    w_ff;
   logic [CNT_BITS-1:0]    n_ff;
   logic                   found_ff;
   logic [IDX_BITS-1:0]    pick_ff;
   logic [LEN_BITS-1:0]    pick_len_ff;
   logic [ADDR_BITS-1:0]   pick_start_ff;
   seg_type                acc_ff;
   logic                   acc_v_ff;
   logic [LEN_BITS-1:0]    free_ff;
   logic [LEN_BITS-1:0]    total_ff;
   logic [ADDR_BITS-1:0]   res_addr_ff;
   logic [CMD_BITS-1:0]    cmd_ff;
   logic [OWNER_BITS-1:0]  owner_ff;
   logic [LEN_BITS-1:0]    size_ff;
   logic [POLICY_BITS-1:0] policy_ff;
   logic                   rsp_valid_ff;
   logic [STATUS_BITS-1:0] rsp_status_ff;
   logic [ADDR_BITS-1:0]   rsp_addr_ff;
   logic [RCNT_BITS-1:0]   rsp_count_ff;

   logic [IDX_BITS-1:0]   rd_idx;
   seg_type               rd_seg;
   logic [LEN_BITS-1:0]   csr_val;
   logic [OWNER_BITS-1:0] rel_owner;
   logic                  rel_hit;
   logic                  merge;
   logic                  fits;
   logic [LEN_BITS-1:0]   rem;
   logic [ADDR_BITS-1:0]  split_start;
   logic [LEN_BITS-1:0]   lift_pos;
   logic                  wr_en;
   logic [IDX_BITS-1:0]   wr_idx;
   seg_type               wr_seg;
   logic                  rsp_free;

   always_comb begin
      unique case (ctl.op)
         OP_SHIFT, OP_LIFT: rd_idx = IDX_BITS'(i_ff - 1'b1);
         default:           rd_idx = i_ff[IDX_BITS-1:0];
      endcase
   end

   assign rd_seg      = table_ff[rd_idx];
   assign csr_val     = (csr_data == '0) ? LEN_BITS'(1) :
                        ((csr_data > MEM_LIMIT) ? MEM_LIMIT : csr_data);
   assign rel_hit     = (rd_seg.owner == owner_ff);
   assign rel_owner   = rel_hit ? '0 : rd_seg.owner;
   assign merge       = acc_v_ff && (acc_ff.owner == '0) && (rel_owner == '0);
   assign fits        = (rd_seg.owner == '0) && (rd_seg.len >= size_ff);
   assign rem         = pick_len_ff - size_ff;
   assign split_start = pick_start_ff + rem[ADDR_BITS-1:0];
   assign lift_pos    = total_ff - rd_seg.len;
   assign rsp_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      wr_en  = 1'b0;
      wr_idx = w_ff[IDX_BITS-1:0];
      wr_seg = rd_seg;
      unique case (ctl.op)
         OP_INIT: begin
            wr_en  = 1'b1;
            wr_idx = '0;
            wr_seg = '{owner: '0, start: '0, len: csr_val};
         end
         OP_TAKE: begin
            wr_en  = 1'b1;
            wr_idx = pick_ff;
            wr_seg = '{owner: owner_ff, start: pick_start_ff, len: pick_len_ff};
         end
         OP_SHIFT: begin
            wr_en  = 1'b1;
            wr_idx = i_ff[IDX_BITS-1:0];
         end
         OP_SPLIT_LO: begin
            wr_en  = 1'b1;
            wr_idx = pick_ff;
            wr_seg = '{owner: '0, start: pick_start_ff, len: rem};
         end
         OP_SPLIT_HI: begin
            wr_en  = 1'b1;
            wr_idx = pick_ff + 1'b1;
            wr_seg = '{owner: owner_ff, start: split_start, len: size_ff};
         end
         OP_REL: begin
            wr_en  = acc_v_ff && !merge;
            wr_seg = acc_ff;
         end
         OP_FLUSH: begin
            wr_en  = 1'b1;
            wr_seg = acc_ff;
         end
         OP_PACK: begin
            wr_en = (rd_seg.owner != '0);
         end
         OP_LIFT: begin
            wr_en  = 1'b1;
            wr_idx = i_ff[IDX_BITS-1:0];
            wr_seg = '{owner: rd_seg.owner, start: lift_pos[ADDR_BITS-1:0], len: rd_seg.len};
         end
         OP_HOLE: begin
            wr_en  = 1'b1;
            wr_idx = '0;
            wr_seg = '{owner: '0, start: '0, len: free_ff};
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_ff[0]  <= '{owner: '0, start: '0, len: MEM_LIMIT};
         count_ff     <= CNT_BITS'(1);
         i_ff         <= '0;
         w_ff         <= '0;
         n_ff         <= '0;
         found_ff     <= 1'b0;
         acc_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            table_ff[wr_idx] <= wr_seg;
         end
         if (ctl.op == OP_FINISH) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (ctl.op)
            OP_INIT: begin
               count_ff <= CNT_BITS'(1);
            end
            OP_LOAD: begin
               cmd_ff      <= req_cmd;
               owner_ff    <= req_owner_id;
               size_ff     <= req_request_size;
               policy_ff   <= req_fit_policy;
               i_ff        <= '0;
               w_ff        <= '0;
               n_ff        <= '0;
               found_ff    <= 1'b0;
               acc_v_ff    <= 1'b0;
               free_ff     <= '0;
               total_ff    <= '0;
               res_addr_ff <= '0;
            end
            OP_SCAN: begin
               i_ff <= i_ff + 1'b1;
               if (fits && (!found_ff ||
                            (policy_ff == POL_BEST && rd_seg.len < pick_len_ff) ||
                            (policy_ff == POL_WORST && rd_seg.len > pick_len_ff))) begin
                  found_ff      <= 1'b1;
                  pick_ff       <= i_ff[IDX_BITS-1:0];
                  pick_len_ff   <= rd_seg.len;
                  pick_start_ff <= rd_seg.start;
               end
            end
            OP_TAKE: begin
               res_addr_ff <= pick_start_ff;
            end
            OP_SHIFT_INIT: begin
               i_ff <= count_ff;
            end
            OP_SHIFT: begin
               i_ff <= i_ff - 1'b1;
            end
            OP_SPLIT_HI: begin
               count_ff    <= count_ff + 1'b1;
               res_addr_ff <= split_start;
            end
            OP_REL: begin
               i_ff <= i_ff + 1'b1;
               if (rel_hit) begin
                  n_ff <= n_ff + 1'b1;
               end
               if (merge) begin
                  acc_ff.len <= acc_ff.len + rd_seg.len;
               end else begin
                  if (acc_v_ff) begin
                     w_ff <= w_ff + 1'b1;
                  end
                  acc_ff   <= '{owner: rel_owner, start: rd_seg.start, len: rd_seg.len};
                  acc_v_ff <= 1'b1;
               end
            end
            OP_FLUSH: begin
               count_ff <= w_ff + 1'b1;
            end
            OP_SUM: begin
               i_ff     <= i_ff + 1'b1;
               total_ff <= total_ff + rd_seg.len;
               if (rd_seg.owner == '0) begin
                  free_ff <= free_ff + rd_seg.len;
               end
            end
            OP_REWIND: begin
               i_ff <= '0;
               w_ff <= '0;
            end
            OP_PACK: begin
               i_ff <= i_ff + 1'b1;
               if (rd_seg.owner != '0) begin
                  w_ff <= w_ff + 1'b1;
               end
            end
            OP_LIFT_INIT: begin
               i_ff     <= w_ff;
               count_ff <= w_ff + 1'b1;
            end
            OP_LIFT: begin
               i_ff     <= i_ff - 1'b1;
               total_ff <= lift_pos;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.op == OP_FINISH) begin
         rsp_status_ff <= ctl.status;
         rsp_addr_ff   <= res_addr_ff;
         rsp_count_ff  <= (cmd_ff == CMD_RELEASE && ctl.status == ST_OK) ?
                          RCNT_BITS'(n_ff) : '0;
      end
   end

   assign sts.cmd        = cmd_ff;
   assign sts.owner_zero = (owner_ff == '0);
   assign sts.size_zero  = (size_ff == '0);
   assign sts.count_le1  = (count_ff <= CNT_BITS'(1));
   assign sts.scan_last  = (i_ff == count_ff - 1'b1);
   assign sts.found      = found_ff;
   assign sts.exact      = (pick_len_ff == size_ff);
   assign sts.full       = (count_ff == CNT_BITS'(MAX_SEGMENTS));
   assign sts.shift_done = (i_ff == CNT_BITS'(pick_ff) + 1'b1);
   assign sts.n_zero     = (n_ff == '0);
   assign sts.free_zero  = (free_ff == '0);
   assign sts.lift_done  = (i_ff == '0);
   assign sts.rsp_free   = rsp_free;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_start_address  = rsp_addr_ff;
   assign rsp_released_count = rsp_count_ff;

endmodule

`default_nettype wire

[rtl/core/csa_ctrl.sv]
// Controller state machine: sequences table scans, shifts and merges.
// Depends on csa_pkg; commands csa_dpath via ctl_type, reads sts_type.
`default_nettype none

module csa_ctrl
   import csa_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire sts_type sts,
   output ctl_type      ctl
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DISPATCH  = 4'd1;
   localparam logic [3:0] S_SCAN      = 4'd2;
   localparam logic [3:0] S_DECIDE    = 4'd3;
   localparam logic [3:0] S_TAKE      = 4'd4;
   localparam logic [3:0] S_SHIFT     = 4'd5;
   localparam logic [3:0] S_SPLIT_LO  = 4'd6;
   localparam logic [3:0] S_SPLIT_HI  = 4'd7;
   localparam logic [3:0] S_REL       = 4'd8;
   localparam logic [3:0] S_FLUSH     = 4'd9;
   localparam logic [3:0] S_SUM       = 4'd10;
   localparam logic [3:0] S_SUM_CHK   = 4'd11;
   localparam logic [3:0] S_PACK      = 4'd12;
   localparam logic [3:0] S_LIFT_INIT = 4'd13;
   localparam logic [3:0] S_LIFT      = 4'd14;
   localparam logic [3:0] S_FINISH    = 4'd15;

   logic [3:0]             state_ff;
   logic [3:0]             state_in;
   logic [STATUS_BITS-1:0] status_ff;
   logic [STATUS_BITS-1:0] status_in;

   always_comb begin
      state_in   = state_ff;
      status_in  = status_ff;
      ctl.op     = OP_NONE;
      ctl.status = status_ff;
      req_ready  = 1'b0;
      csr_ready  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            csr_ready = 1'b1;
            req_ready = !csr_valid;
            if (csr_valid) begin
               ctl.op = OP_INIT;
            end else if (req_valid) begin
               ctl.op   = OP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            priority if (sts.cmd == CMD_REQUEST) begin
               if (sts.owner_zero) begin
                  status_in = ST_NOOWNER;
                  state_in  = S_FINISH;
               end else if (sts.size_zero) begin
                  status_in = ST_NOFIT;
                  state_in  = S_FINISH;
               end else begin
                  state_in = S_SCAN;
               end
            end else if (sts.cmd == CMD_RELEASE) begin
               if (sts.owner_zero) begin
                  status_in = ST_NOOWNER;
                  state_in  = S_FINISH;
               end else begin
                  state_in = S_REL;
               end
            end else if (sts.cmd == CMD_COMPACT) begin
               if (sts.count_le1) begin
                  status_in = ST_NOCOMPACT;
                  state_in  = S_FINISH;
               end else begin
                  state_in = S_SUM;
               end
            end else begin
               status_in = ST_OK;
               state_in  = S_FINISH;
            end
         end
         S_SCAN: begin
            ctl.op = OP_SCAN;
            if (sts.scan_last) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            priority if (!sts.found) begin
               status_in = ST_NOFIT;
               state_in  = S_FINISH;
            end else if (sts.exact) begin
               state_in = S_TAKE;
            end else if (sts.full) begin
               status_in = ST_FULL;
               state_in  = S_FINISH;
            end else begin
               ctl.op   = OP_SHIFT_INIT;
               state_in = S_SHIFT;
            end
         end
         S_TAKE: begin
            ctl.op    = OP_TAKE;
            status_in = ST_OK;
            state_in  = S_FINISH;
         end
         S_SHIFT: begin
            if (sts.shift_done) begin
               state_in = S_SPLIT_LO;
            end else begin
               ctl.op = OP_SHIFT;
            end
         end
         S_SPLIT_LO: begin
            ctl.op   = OP_SPLIT_LO;
            state_in = S_SPLIT_HI;
         end
         S_SPLIT_HI: begin
            ctl.op    = OP_SPLIT_HI;
            status_in = ST_OK;
            state_in  = S_FINISH;
         end
         S_REL: begin
            ctl.op = OP_REL;
            if (sts.scan_last) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            ctl.op    = OP_FLUSH;
            status_in = sts.n_zero ? ST_NOOWNER : ST_OK;
            state_in  = S_FINISH;
         end
         S_SUM: begin
            ctl.op = OP_SUM;
            if (sts.scan_last) begin
               state_in = S_SUM_CHK;
            end
         end
         S_SUM_CHK: begin
            if (sts.free_zero) begin
               status_in = ST_OK;
               state_in  = S_FINISH;
            end else begin
               ctl.op   = OP_REWIND;
               state_in = S_PACK;
            end
         end
         S_PACK: begin
            ctl.op = OP_PACK;
            if (sts.scan_last) begin
               state_in = S_LIFT_INIT;
            end
         end
         S_LIFT_INIT: begin
            ctl.op   = OP_LIFT_INIT;
            state_in = S_LIFT;
         end
         S_LIFT: begin
            if (sts.lift_done) begin
               ctl.op    = OP_HOLE;
               status_in = ST_OK;
               state_in  = S_FINISH;
            end else begin
               ctl.op = OP_LIFT;
            end
         end
         S_FINISH: begin
            if (sts.rsp_free) begin
               ctl.op   = OP_FINISH;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= ST_OK;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/contiguous_segment_allocator_core.sv]
// Contiguous segment allocator: request, release and compact over a segment table.
// Some commands are answered at dispatch; a request scans every entry and, on a split,
// shifts the entries above the picked one; a release scans every entry; a compact sums
// every entry and, with free space, packs and lifts the owned entries. One transaction
// at a time; the next is accepted in the cycle after the response is loaded unless a csr
// write is pending. Reset leaves one hole of 2^20 units; a csr write re-creates one hole.
// Depends on csa_pkg, csa_if, csa_ctrl and csa_dpath.
`default_nettype none

module contiguous_segment_allocator_core
   import csa_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   csa_req_if.sink   req_chan,
   csa_rsp_if.source rsp_chan,
   csa_csr_if.sink   csr_chan
);

   ctl_type ctl;
   sts_type sts;

   csa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .csr_valid (csr_chan.valid),
      .csr_ready (csr_chan.ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   csa_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .sts                (sts),
      .req_cmd            (req_chan.cmd),
      .req_owner_id       (req_chan.owner_id),
      .req_request_size   (req_chan.request_size),
      .req_fit_policy     (req_chan.fit_policy),
      .csr_data           (csr_chan.data),
      .rsp_valid          (rsp_chan.valid),
      .rsp_ready          (rsp_chan.ready),
      .rsp_status         (rsp_chan.status),
      .rsp_start_address  (rsp_chan.start_address),
      .rsp_released_count (rsp_chan.released_count)
   );

endmodule

`default_nettype wire
